// File: rtl/gkd_pkg.sv
// Shared types and constants for the Gaussian kernel with derivatives block.
`default_nettype none

package gkd_pkg;

    localparam int OP_W     = 3;
    localparam int H_W      = 16;
    localparam int KV_W     = 22;
    localparam int CUTOFF_W = 9;
    localparam int E_W      = 25;   // exp samples, Q1.24
    localparam int C_W      = 38;   // signed coefficient ahead of the final multiply

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 9'd100;

    // derivative degree codes
    localparam logic [OP_W-1:0] DEG_COV = 3'd0;
    localparam logic [OP_W-1:0] DEG_D1  = 3'd1;
    localparam logic [OP_W-1:0] DEG_D2  = 3'd2;
    localparam logic [OP_W-1:0] DEG_D3  = 3'd3;
    localparam logic [OP_W-1:0] DEG_D4  = 3'd4;

    localparam logic signed [C_W-1:0] ONE_Q24   = 38'sd16777216;
    localparam logic signed [C_W-1:0] TWO_Q24   = 38'sd33554432;
    localparam logic signed [C_W-1:0] THREE_Q24 = 38'sd50331648;

    typedef logic [OP_W-1:0]            t_op;
    typedef logic [H_W-1:0]             t_dist;
    typedef logic signed [KV_W-1:0]     t_kval;

endpackage

`default_nettype wire

// File: rtl/gkd_if.sv
// Valid/ready stream interfaces for the input and result words.
`default_nettype none

interface gkd_in_if;
    import gkd_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_dist distance_h;

    modport source(output valid, operation, distance_h, input ready);
    modport sink(input valid, operation, distance_h, output ready);
endinterface

interface gkd_out_if;
    import gkd_pkg::*;

    logic  valid;
    logic  ready;
    t_kval kernel_value;

    modport source(output valid, kernel_value, input ready);
    modport sink(input valid, kernel_value, output ready);
endinterface

`default_nettype wire

// File: rtl/gaussian_kernel_with_derivatives_top.sv
// Gaussian covariance exp(-h^2) and its first four derivatives, six-stage pipeline.
// One word enters per cycle unless stalled; results leave from stage 6. The pipeline
// advances as a whole whenever the output register is empty or taken, so a stall
// at the output holds every stage and input ready drops in the same cycle.
// h is unsigned Q4.12, the result signed Q5.16. exp(-x) is read from a constant
// ROM of EXP_TABLE_DEPTH+1 Q1.24 samples over 0..16 with two read ports per cycle
// (neighbor samples) and linear interpolation. Degree codes above 4, h^2 above
// the exp_cutoff register, and h^2 of 16 or more give 0. The ROM is built at
// elaboration, so the block needs no initialization time after reset.
`default_nettype none

module gaussian_kernel_with_derivatives_top #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [gkd_pkg::CUTOFF_W-1:0]  i_cfg_wdata,
    gkd_in_if.sink                             i_in,
    gkd_out_if.source                          o_out
);
    import gkd_pkg::*;

    localparam int AW    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W = 28 + AW;
    localparam logic [63:0] EXP_STEP = (64'd16 << 32) / EXP_TABLE_DEPTH;

    typedef logic [E_W-1:0] t_rom [0:EXP_TABLE_DEPTH];

    function automatic t_rom f_build_rom(input logic [63:0] step);
        t_rom        rom;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] acc;
        int          k;
        r   = 64'd1 << 32;
        t   = r;
        acc = r;
        for (k = 1; k <= 16; k++) begin
            t = ((t * step) >> 32) / 64'(k);
            if (k[0]) begin
                r = r - t;
            end else begin
                r = r + t;
            end
        end
        for (k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            rom[k] = E_W'((acc + 64'd128) >> 8);
            acc    = (acc * r) >> 32;
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = f_build_rom(EXP_STEP);

    logic                adv;
    logic [5:0]          r_vld;
    logic [CUTOFF_W-1:0] r_exp_cutoff;

    // stage 1
    logic [31:0]     s1_h2;
    t_op             r1_deg;
    logic [H_W-1:0]  r1_h;
    logic [31:0]     r1_h2;

    // stage 2
    logic            s2_zero;
    logic [POS_W-1:0] s2_pos;
    logic            r2_zero;
    t_op             r2_deg;
    logic [13:0]     r2_h;
    logic [27:0]     r2_h2;
    logic [AW-1:0]   r2_idx;
    logic [23:0]     r2_frac;

    // stage 3
    logic signed [30:0] s3_p3;
    logic signed [44:0] s3_p3x;
    logic [E_W-1:0]     r3_rom_a;
    logic [E_W-1:0]     r3_rom_b;
    logic [55:0]        r3_h4raw;
    logic signed [44:0] r3_q3raw;
    logic               r3_zero;
    t_op                r3_deg;
    logic [13:0]        r3_h;
    logic [27:0]        r3_h2;
    logic [23:0]        r3_frac;

    // stage 4
    logic [E_W-1:0]     s4_diff;
    logic [55:0]        s4_h4sum;
    logic [31:0]        s4_h4;
    logic signed [44:0] s4_qsum;
    logic signed [32:0] s4_q;
    logic signed [C_W-1:0] s4_h2x;
    logic signed [C_W-1:0] s4_h4x;
    logic signed [C_W-1:0] s4_p4;
    logic signed [C_W-1:0] s4_c;
    logic [48:0]        r4_dmul;
    logic [E_W-1:0]     r4_a;
    logic signed [C_W-1:0] r4_c;

    // stage 5
    logic [E_W-1:0]     s5_e;
    logic [43:0]        r5_pl;
    logic signed [43:0] r5_ph;
    logic               r5_neg;

    // stage 6
    logic signed [63:0] s6_hi;
    logic signed [63:0] s6_lo;
    logic signed [63:0] s6_sum;
    t_kval              r6_res;

    assign adv                = !r_vld[5] || o_out.ready;
    assign i_in.ready         = adv;
    assign o_out.valid        = r_vld[5];
    assign o_out.kernel_value = r6_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cutoff <= CUTOFF_RESET;
        end else if (i_cfg_we) begin
            r_exp_cutoff <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[4:0], i_in.valid};
        end
    end

    // stage 1: h^2 in Q8.24
    assign s1_h2 = {16'b0, i_in.distance_h} * {16'b0, i_in.distance_h};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_deg <= i_in.operation;
            r1_h   <= i_in.distance_h;
            r1_h2  <= s1_h2;
        end
    end

    // stage 2: zero conditions and table position
    assign s2_zero = (r1_h2[31:28] != 4'd0)
                  || ({1'b0, r1_h2} > {r_exp_cutoff, 24'b0})
                  || (r1_deg > DEG_D4);
    assign s2_pos  = POS_W'(r1_h2[27:0]) * POS_W'(EXP_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_zero <= s2_zero;
            r2_deg  <= r1_deg;
            r2_h    <= r1_h[13:0];
            r2_h2   <= r1_h2[27:0];
            r2_idx  <= s2_pos[POS_W-1:28];
            r2_frac <= s2_pos[27:4];
        end
    end

    // stage 3: ROM read, h^4 and (3 - 2h^2) * h products
    assign s3_p3  = 31'sd50331648 - $signed({2'b00, r2_h2, 1'b0});
    assign s3_p3x = 45'(s3_p3);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_rom_a <= EXP_ROM[r2_idx];
            r3_rom_b <= EXP_ROM[AW'(r2_idx + AW'(1))];
            r3_h4raw <= 56'(r2_h2) * 56'(r2_h2);
            r3_q3raw <= s3_p3x * $signed({31'b0, r2_h});
            r3_zero  <= r2_zero;
            r3_deg   <= r2_deg;
            r3_h     <= r2_h;
            r3_h2    <= r2_h2;
            r3_frac  <= r2_frac;
        end
    end

    // stage 4: interpolation product and per-degree coefficient
    assign s4_diff  = r3_rom_a - r3_rom_b;
    assign s4_h4sum = r3_h4raw + (56'd1 << 23);
    assign s4_h4    = s4_h4sum[55:24];
    assign s4_qsum  = r3_q3raw + 45'sd2048 - $signed({44'b0, r3_q3raw[44]});
    assign s4_q     = s4_qsum[44:12];
    assign s4_h2x   = $signed({10'b0, r3_h2});
    assign s4_h4x   = $signed({6'b0, s4_h4});
    assign s4_p4    = THREE_Q24 - 38'sd12 * s4_h2x + 38'sd4 * s4_h4x;

    always_comb begin
        s4_c = '0;
        if (!r3_zero) begin
            case (r3_deg)
                DEG_COV: s4_c = ONE_Q24;
                DEG_D1:  s4_c = -$signed({11'b0, r3_h, 13'b0});
                DEG_D2:  s4_c = $signed({8'b0, r3_h2, 2'b0}) - TWO_Q24;
                DEG_D3:  s4_c = $signed({{3{s4_q[32]}}, s4_q, 2'b0});
                DEG_D4:  s4_c = s4_p4 <<< 2;
                default: s4_c = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_dmul <= 49'(s4_diff) * 49'(r3_frac);
            r4_a    <= r3_rom_a;
            r4_c    <= s4_c;
        end
    end

    // stage 5: e and coefficient times e, split in two partial products
    assign s5_e = r4_a - r4_dmul[48:24];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_pl  <= 44'(r4_c[18:0]) * 44'(s5_e);
            r5_ph  <= $signed({{25{r4_c[C_W-1]}}, r4_c[C_W-1:19]}) * $signed({19'b0, s5_e});
            r5_neg <= r4_c[C_W-1];
        end
    end

    // stage 6: sum and round to nearest, ties away from zero
    assign s6_hi  = $signed({r5_ph[43], r5_ph, 19'b0});
    assign s6_lo  = $signed({20'b0, r5_pl});
    assign s6_sum = s6_hi + s6_lo + 64'sd2147483648 - $signed({63'b0, r5_neg});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_res <= s6_sum[53:32];
        end
    end

    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r2_idx < AW'(EXP_TABLE_DEPTH)))
        else $error("table index past last segment");

    a_rom_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_rom_a >= r3_rom_b))
        else $error("exp samples not decreasing");

    a_interp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r4_dmul[48:24] <= r4_a))
        else $error("interpolation step exceeds sample");

endmodule

`default_nettype wire
